// File: rtl/rexab_pkg.sv
// Shared types, selector codes and constants for the execute stage.
// No dependencies; every other rtl file refers to this package by scope.
`timescale 1ns / 1ps
`default_nettype none
package rexab_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int MUL_LAT    = 3;
   localparam int DIV_LAT    = DATA_WIDTH + 2;

   typedef enum logic [5:0] {
      F_ADD = 6'd0, F_ADDU = 6'd1, F_ADDIU = 6'd2, F_SUB = 6'd3, F_SUBU = 6'd4,
      F_MUL = 6'd5, F_MULU = 6'd6, F_DIV = 6'd7, F_DIVU = 6'd8, F_MUL2 = 6'd9,
      F_MULU2 = 6'd10, F_DIV2 = 6'd11, F_DIVU2 = 6'd12, F_XOR = 6'd13,
      F_XORU = 6'd14, F_NEG = 6'd15, F_NEGU = 6'd16, F_REM = 6'd17,
      F_REMU = 6'd18, F_LI = 6'd19, F_SEQ = 6'd20, F_SGE = 6'd21, F_SGT = 6'd22,
      F_SLE = 6'd23, F_SLT = 6'd24, F_SNE = 6'd25, F_B = 6'd26, F_BEQ = 6'd27,
      F_BNE = 6'd28, F_BGE = 6'd29, F_BLE = 6'd30, F_BGT = 6'd31, F_BLT = 6'd32,
      F_BEQZ = 6'd33, F_BNEZ = 6'd34, F_BGEZ = 6'd35, F_BLEZ = 6'd36,
      F_BGTZ = 6'd37, F_BLTZ = 6'd38, F_J = 6'd39, F_JR = 6'd40, F_JAL = 6'd41,
      F_JALR = 6'd42, F_LA = 6'd43, F_LB = 6'd44, F_LH = 6'd45, F_LW = 6'd46,
      F_SB = 6'd47, F_SH = 6'd48, F_SW = 6'd49, F_MOVE = 6'd50, F_MFHI = 6'd51,
      F_MFLO = 6'd52, F_NOP = 6'd53, F_SYSCALL = 6'd54
   } func_type;

   typedef enum logic [3:0] {
      K_NONE = 4'd0, K_REG = 4'd1, K_HILO = 4'd2, K_LINK = 4'd3, K_LOAD = 4'd4,
      K_STORE = 4'd5, K_PRINT_INT = 4'd6, K_PRINT_STR = 4'd7, K_READ_INT = 4'd8,
      K_READ_STR = 4'd9, K_SBRK = 4'd10, K_EXIT = 4'd11, K_EXIT_CODE = 4'd12
   } kind_type;

   typedef enum logic [2:0] {
      CLS_ALU = 3'd0, CLS_MUL_LO = 3'd1, CLS_MUL_HL = 3'd2, CLS_DIV_Q = 3'd3,
      CLS_DIV_QR = 3'd4, CLS_REM = 3'd5
   } cls_type;

   localparam logic [DATA_WIDTH-1:0] PC_REG = 32'd34;
   localparam logic [DATA_WIDTH-1:0] SYS_PRINT_INT = 32'd1;
   localparam logic [DATA_WIDTH-1:0] SYS_PRINT_STR = 32'd4;
   localparam logic [DATA_WIDTH-1:0] SYS_READ_INT  = 32'd5;
   localparam logic [DATA_WIDTH-1:0] SYS_READ_STR  = 32'd8;
   localparam logic [DATA_WIDTH-1:0] SYS_SBRK      = 32'd9;
   localparam logic [DATA_WIDTH-1:0] SYS_EXIT      = 32'd10;
   localparam logic [DATA_WIDTH-1:0] SYS_EXIT_CODE = 32'd17;
   localparam logic [1:0] ARG_LABEL = 2'd3;
   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [2:0] SIZE_WORD = 3'd4;

   typedef struct packed {
      logic [5:0]                   func;
      logic signed [DATA_WIDTH-1:0] operand_a;
      logic signed [DATA_WIDTH-1:0] operand_b;
      logic signed [DATA_WIDTH-1:0] operand_c;
      logic [1:0]                   arg_count;
   } req_type;

   typedef struct packed {
      logic [3:0]                   result_kind;
      logic signed [DATA_WIDTH-1:0] out_first;
      logic signed [DATA_WIDTH-1:0] out_second;
      logic [2:0]                   out_third;
      logic                         div_by_zero;
   } rsp_type;

   typedef struct packed {
      cls_type cls;
      rsp_type rsp;
   } alu_res_type;

   typedef struct packed {
      logic                  qneg;
      logic                  rneg;
      logic                  dz;
      logic [DATA_WIDTH-1:0] raw;
   } div_meta_type;

endpackage
`default_nettype wire

// File: rtl/risc_execute_stage_alu_branch_top.sv
// Execute stage top: input register, ALU, multiplier, divider, merge, output.
// Depends on rexab_pkg, rexab_alu, rexab_mul and rexab_div.
//
//   channel  ports                        handshake
//   req      start, busy, req_payload     beat taken when start && !busy
//   rsp      rsp_valid, rsp_payload       one-cycle strobe, never held off
//
// One instruction per cycle, every cycle outside reset. Results pass the input
// register, the divider's one-bit-per-stage pipeline and the output register;
// all other ops ride a matching delay line.
// busy is high only during reset. Synchronous reset clears the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module risc_execute_stage_alu_branch_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire rexab_pkg::req_type req_payload,
   output logic                    rsp_valid,
   output rexab_pkg::rsp_type      rsp_payload
);
   localparam int W   = rexab_pkg::DATA_WIDTH;
   localparam int LAT = rexab_pkg::DIV_LAT;
   localparam int MPAD = rexab_pkg::DIV_LAT - rexab_pkg::MUL_LAT;

   logic               s0_valid_ff;
   rexab_pkg::req_type s0_ff;
   logic               accept;
   logic [LAT-1:0]     valid_ff;
   rexab_pkg::alu_res_type alu_res;
   rexab_pkg::alu_res_type res_line_ff [0:LAT-2];
   logic [W-1:0]       mul_a, mul_b, div_n, div_d, mul_lo, mul_hi, quot, rem;
   logic               mul_sgn, div_sgn, dz;
   logic [W-1:0]       lo_line_ff [0:MPAD-1];
   logic [W-1:0]       hi_line_ff [0:MPAD-1];
   rexab_pkg::rsp_type rsp_in;
   rexab_pkg::alu_res_type tail;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      s0_ff <= req_payload;
      if (reset) begin
         s0_valid_ff <= 1'b0;
         valid_ff    <= '0;
         rsp_valid   <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         valid_ff    <= {valid_ff[LAT-2:0], s0_valid_ff};
         rsp_valid   <= valid_ff[LAT-1];
      end
   end

   rexab_alu u_alu (.clock(clock), .req(s0_ff), .res_ff(alu_res));

   // Two-operand hi/lo forms use a,b; the rest use b,c.
   always_comb begin
      mul_a = s0_ff.operand_b;
      mul_b = s0_ff.operand_c;
      div_n = s0_ff.operand_b;
      div_d = s0_ff.operand_c;
      if (s0_ff.func == rexab_pkg::F_MUL2 || s0_ff.func == rexab_pkg::F_MULU2) begin
         mul_a = s0_ff.operand_a;
         mul_b = s0_ff.operand_b;
      end
      if (s0_ff.func == rexab_pkg::F_DIV2 || s0_ff.func == rexab_pkg::F_DIVU2) begin
         div_n = s0_ff.operand_a;
         div_d = s0_ff.operand_b;
      end
      mul_sgn = (s0_ff.func == rexab_pkg::F_MUL2);
      div_sgn = (s0_ff.func == rexab_pkg::F_DIV) || (s0_ff.func == rexab_pkg::F_DIV2) ||
                (s0_ff.func == rexab_pkg::F_REM);
   end

   rexab_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .is_signed(mul_sgn),
                    .lo_ff(mul_lo), .hi_ff(mul_hi));

   rexab_div u_div (.clock(clock), .dividend(div_n), .divisor(div_d), .is_signed(div_sgn),
                    .quot_ff(quot), .rem_ff(rem), .dz_ff(dz));

   // Align ALU and multiplier results with the divider output.
   always_ff @(posedge clock) begin
      res_line_ff[0] <= alu_res;
      for (int i = 1; i < LAT - 1; i++) res_line_ff[i] <= res_line_ff[i-1];
      lo_line_ff[0] <= mul_lo;
      hi_line_ff[0] <= mul_hi;
      for (int i = 1; i < MPAD; i++) begin
         lo_line_ff[i] <= lo_line_ff[i-1];
         hi_line_ff[i] <= hi_line_ff[i-1];
      end
   end

   assign tail = res_line_ff[LAT-2];

   always_comb begin
      rsp_in = tail.rsp;
      unique case (tail.cls)
         rexab_pkg::CLS_ALU: ;
         rexab_pkg::CLS_MUL_LO: rsp_in.out_second = lo_line_ff[MPAD-1];
         rexab_pkg::CLS_MUL_HL: begin
            rsp_in.out_first  = lo_line_ff[MPAD-1];
            rsp_in.out_second = hi_line_ff[MPAD-1];
         end
         rexab_pkg::CLS_DIV_Q: begin
            rsp_in.out_second  = quot;
            rsp_in.div_by_zero = dz;
         end
         rexab_pkg::CLS_DIV_QR: begin
            rsp_in.out_first   = quot;
            rsp_in.out_second  = rem;
            rsp_in.div_by_zero = dz;
         end
         rexab_pkg::CLS_REM: begin
            rsp_in.out_second  = rem;
            rsp_in.div_by_zero = dz;
         end
         default: rsp_in = tail.rsp;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_payload <= rsp_in;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT + 2))
      else $error("result without matching accepted beat");
   a_dz_kind: assert property (@(posedge clock)
      rsp_valid && rsp_payload.div_by_zero |->
         rsp_payload.result_kind == rexab_pkg::K_REG ||
         rsp_payload.result_kind == rexab_pkg::K_HILO)
      else $error("divide flag on non-divide result");
   a_size_kind: assert property (@(posedge clock)
      rsp_valid && rsp_payload.out_third != '0 |->
         rsp_payload.result_kind == rexab_pkg::K_LOAD ||
         rsp_payload.result_kind == rexab_pkg::K_STORE)
      else $error("access size on non-memory result");
endmodule
`default_nettype wire

// File: rtl/rexab_alu.sv
// Registered decode and ALU: arithmetic, compares, branches, loads/stores, syscalls.
// Tags divide and multiply ops with a class for the final merge; uses rexab_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rexab_alu (
   input  wire logic             clock,
   input  wire rexab_pkg::req_type     req,
   output rexab_pkg::alu_res_type      res_ff
);
   rexab_pkg::alu_res_type res_in;
   logic [rexab_pkg::DATA_WIDTH-1:0] a, b, c, addr;
   logic signed [rexab_pkg::DATA_WIDTH-1:0] sa, sb, sc;
   logic take;

   assign a = req.operand_a;
   assign b = req.operand_b;
   assign c = req.operand_c;
   assign sa = req.operand_a;
   assign sb = req.operand_b;
   assign sc = req.operand_c;
   assign addr = (req.arg_count == rexab_pkg::ARG_LABEL) ? b : b + c;

   always_comb begin
      res_in = '0;
      res_in.cls = rexab_pkg::CLS_ALU;
      take = 1'b0;
      unique case (req.func)
         rexab_pkg::F_ADD, rexab_pkg::F_ADDU, rexab_pkg::F_ADDIU: begin
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
            res_in.rsp.out_second = b + c;
         end
         rexab_pkg::F_SUB, rexab_pkg::F_SUBU: begin
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
            res_in.rsp.out_second = b - c;
         end
         rexab_pkg::F_MUL, rexab_pkg::F_MULU: begin
            res_in.cls = rexab_pkg::CLS_MUL_LO;
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
         end
         rexab_pkg::F_DIV, rexab_pkg::F_DIVU: begin
            res_in.cls = rexab_pkg::CLS_DIV_Q;
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
         end
         rexab_pkg::F_MUL2, rexab_pkg::F_MULU2: begin
            res_in.cls = rexab_pkg::CLS_MUL_HL;
            res_in.rsp.result_kind = rexab_pkg::K_HILO;
         end
         rexab_pkg::F_DIV2, rexab_pkg::F_DIVU2: begin
            res_in.cls = rexab_pkg::CLS_DIV_QR;
            res_in.rsp.result_kind = rexab_pkg::K_HILO;
         end
         rexab_pkg::F_XOR, rexab_pkg::F_XORU: begin
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
            res_in.rsp.out_second = b ^ c;
         end
         rexab_pkg::F_NEG, rexab_pkg::F_NEGU: begin
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
            res_in.rsp.out_second = '0 - b;
         end
         rexab_pkg::F_REM, rexab_pkg::F_REMU: begin
            res_in.cls = rexab_pkg::CLS_REM;
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
         end
         rexab_pkg::F_LI, rexab_pkg::F_LA, rexab_pkg::F_MOVE, rexab_pkg::F_MFHI,
         rexab_pkg::F_MFLO: begin
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
            res_in.rsp.out_second = b;
         end
         rexab_pkg::F_SEQ, rexab_pkg::F_SGE, rexab_pkg::F_SGT, rexab_pkg::F_SLE,
         rexab_pkg::F_SLT, rexab_pkg::F_SNE: begin
            res_in.rsp.result_kind = rexab_pkg::K_REG;
            res_in.rsp.out_first = a;
            unique case (req.func)
               rexab_pkg::F_SEQ: res_in.rsp.out_second[0] = (sb == sc);
               rexab_pkg::F_SGE: res_in.rsp.out_second[0] = (sb >= sc);
               rexab_pkg::F_SGT: res_in.rsp.out_second[0] = (sb > sc);
               rexab_pkg::F_SLE: res_in.rsp.out_second[0] = (sb <= sc);
               rexab_pkg::F_SLT: res_in.rsp.out_second[0] = (sb < sc);
               default:          res_in.rsp.out_second[0] = (sb != sc);
            endcase
         end
         rexab_pkg::F_B, rexab_pkg::F_J, rexab_pkg::F_JR: begin
            take = 1'b1;
            res_in.rsp.out_second = a;
         end
         rexab_pkg::F_BEQ, rexab_pkg::F_BNE, rexab_pkg::F_BGE, rexab_pkg::F_BLE,
         rexab_pkg::F_BGT, rexab_pkg::F_BLT: begin
            res_in.rsp.out_second = c;
            unique case (req.func)
               rexab_pkg::F_BEQ: take = (sa == sb);
               rexab_pkg::F_BNE: take = (sa != sb);
               rexab_pkg::F_BGE: take = (sa >= sb);
               rexab_pkg::F_BLE: take = (sa <= sb);
               rexab_pkg::F_BGT: take = (sa > sb);
               default:          take = (sa < sb);
            endcase
         end
         rexab_pkg::F_BEQZ, rexab_pkg::F_BNEZ, rexab_pkg::F_BGEZ, rexab_pkg::F_BLEZ,
         rexab_pkg::F_BGTZ, rexab_pkg::F_BLTZ: begin
            res_in.rsp.out_second = b;
            unique case (req.func)
               rexab_pkg::F_BEQZ: take = (sa == 0);
               rexab_pkg::F_BNEZ: take = (sa != 0);
               rexab_pkg::F_BGEZ: take = (sa >= 0);
               rexab_pkg::F_BLEZ: take = (sa <= 0);
               rexab_pkg::F_BGTZ: take = (sa > 0);
               default:           take = (sa < 0);
            endcase
         end
         rexab_pkg::F_JAL, rexab_pkg::F_JALR: begin
            res_in.rsp.result_kind = rexab_pkg::K_LINK;
            res_in.rsp.out_first = a;
            res_in.rsp.out_second = b;
         end
         rexab_pkg::F_LB, rexab_pkg::F_LH, rexab_pkg::F_LW: begin
            res_in.rsp.result_kind = rexab_pkg::K_LOAD;
            res_in.rsp.out_first = a;
            res_in.rsp.out_second = addr;
            res_in.rsp.out_third = (req.func == rexab_pkg::F_LB) ? rexab_pkg::SIZE_BYTE :
               ((req.func == rexab_pkg::F_LH) ? rexab_pkg::SIZE_HALF : rexab_pkg::SIZE_WORD);
         end
         rexab_pkg::F_SB, rexab_pkg::F_SH, rexab_pkg::F_SW: begin
            res_in.rsp.result_kind = rexab_pkg::K_STORE;
            res_in.rsp.out_first = a;
            res_in.rsp.out_second = addr;
            res_in.rsp.out_third = (req.func == rexab_pkg::F_SB) ? rexab_pkg::SIZE_BYTE :
               ((req.func == rexab_pkg::F_SH) ? rexab_pkg::SIZE_HALF : rexab_pkg::SIZE_WORD);
         end
         rexab_pkg::F_SYSCALL: begin
            unique case (a)
               rexab_pkg::SYS_PRINT_INT: begin
                  res_in.rsp.result_kind = rexab_pkg::K_PRINT_INT;
                  res_in.rsp.out_first = b;
               end
               rexab_pkg::SYS_PRINT_STR: begin
                  res_in.rsp.result_kind = rexab_pkg::K_PRINT_STR;
                  res_in.rsp.out_first = b;
               end
               rexab_pkg::SYS_READ_INT: res_in.rsp.result_kind = rexab_pkg::K_READ_INT;
               rexab_pkg::SYS_READ_STR: begin
                  res_in.rsp.result_kind = rexab_pkg::K_READ_STR;
                  res_in.rsp.out_first = b;
                  res_in.rsp.out_second = c;
               end
               rexab_pkg::SYS_SBRK: begin
                  res_in.rsp.result_kind = rexab_pkg::K_SBRK;
                  res_in.rsp.out_first = b;
               end
               rexab_pkg::SYS_EXIT: res_in.rsp.result_kind = rexab_pkg::K_EXIT;
               rexab_pkg::SYS_EXIT_CODE: begin
                  res_in.rsp.result_kind = rexab_pkg::K_EXIT_CODE;
                  res_in.rsp.out_first = b;
               end
               default: res_in.rsp.result_kind = rexab_pkg::K_NONE;
            endcase
         end
         default: res_in.rsp = '0;
      endcase
      // Taken branch writes the target to the pc register; not taken drops out.
      if (take) begin
         res_in.rsp.result_kind = rexab_pkg::K_REG;
         res_in.rsp.out_first = rexab_pkg::PC_REG;
      end else if (res_in.rsp.result_kind == rexab_pkg::K_NONE) begin
         res_in.rsp = '0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end
endmodule
`default_nettype wire

// File: rtl/rexab_mul.sv
// Three-stage 32x32 multiplier, signed or unsigned, full 64-bit product.
// Unsigned core product with a sign correction on the hi word; uses rexab_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rexab_mul (
   input  wire logic                             clock,
   input  wire logic [rexab_pkg::DATA_WIDTH-1:0] op_a,
   input  wire logic [rexab_pkg::DATA_WIDTH-1:0] op_b,
   input  wire logic                             is_signed,
   output logic [rexab_pkg::DATA_WIDTH-1:0]      lo_ff,
   output logic [rexab_pkg::DATA_WIDTH-1:0]      hi_ff
);
   localparam int W = rexab_pkg::DATA_WIDTH;
   logic [W-1:0]   a_ff, b_ff;
   logic           sgn_ff;
   logic [2*W-1:0] prod_ff, prod_in;
   logic [W-1:0]   corr_ff, corr_in;

   // Signed product hi = unsigned hi - (a<0 ? b : 0) - (b<0 ? a : 0).
   assign prod_in = {{W{1'b0}}, a_ff} * {{W{1'b0}}, b_ff};
   assign corr_in = ((sgn_ff && a_ff[W-1]) ? b_ff : '0) + ((sgn_ff && b_ff[W-1]) ? a_ff : '0);

   always_ff @(posedge clock) begin
      a_ff    <= op_a;
      b_ff    <= op_b;
      sgn_ff  <= is_signed;
      prod_ff <= prod_in;
      corr_ff <= corr_in;
      lo_ff   <= prod_ff[W-1:0];
      hi_ff   <= prod_ff[2*W-1:W] - corr_ff;
   end
endmodule
`default_nettype wire

// File: rtl/rexab_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed or unsigned.
// Zero divisor gives quotient 0, remainder = dividend and a flag; uses rexab_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rexab_div (
   input  wire logic                             clock,
   input  wire logic [rexab_pkg::DATA_WIDTH-1:0] dividend,
   input  wire logic [rexab_pkg::DATA_WIDTH-1:0] divisor,
   input  wire logic                             is_signed,
   output logic [rexab_pkg::DATA_WIDTH-1:0]      quot_ff,
   output logic [rexab_pkg::DATA_WIDTH-1:0]      rem_ff,
   output logic                                  dz_ff
);
   localparam int W = rexab_pkg::DATA_WIDTH;
   logic [W-1:0] num_ff [0:W];
   logic [W-1:0] part_ff [0:W];
   logic [W-1:0] den_ff [0:W];
   rexab_pkg::div_meta_type meta_ff [0:W];
   logic nneg, dneg;

   assign nneg = is_signed && dividend[W-1];
   assign dneg = is_signed && divisor[W-1];

   always_ff @(posedge clock) begin
      num_ff[0]       <= nneg ? '0 - dividend : dividend;
      den_ff[0]       <= dneg ? '0 - divisor : divisor;
      part_ff[0]      <= '0;
      meta_ff[0].qneg <= nneg ^ dneg;
      meta_ff[0].rneg <= nneg;
      meta_ff[0].dz   <= (divisor == '0);
      meta_ff[0].raw  <= dividend;
   end

   for (genvar g = 0; g < W; g++) begin : g_step
      logic [W:0] trial;
      logic       fit;
      assign trial = {part_ff[g], num_ff[g][W-1]};
      assign fit   = trial >= {1'b0, den_ff[g]};
      always_ff @(posedge clock) begin
         part_ff[g+1] <= fit ? W'(trial - {1'b0, den_ff[g]}) : trial[W-1:0];
         num_ff[g+1]  <= {num_ff[g][W-2:0], fit};
         den_ff[g+1]  <= den_ff[g];
         meta_ff[g+1] <= meta_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      dz_ff <= meta_ff[W].dz;
      if (meta_ff[W].dz) begin
         quot_ff <= '0;
         rem_ff  <= meta_ff[W].raw;
      end else begin
         quot_ff <= meta_ff[W].qneg ? '0 - num_ff[W] : num_ff[W];
         rem_ff  <= meta_ff[W].rneg ? '0 - part_ff[W] : part_ff[W];
      end
   end
endmodule
`default_nettype wire
